FILE: sv/nmea_cks_pkg.sv
`default_nettype none
package nmea_cks_pkg;

	localparam logic [7:0] STAR_CHAR  = 8'h2A;
	localparam int         PREFIX_LEN = 6;
	localparam int         POS_W      = $clog2(PREFIX_LEN + 1);

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_RMC   = 2'd1,
		KIND_HDT   = 2'd2
	} kind_t;

	// Characters of the two recognized talker/sentence prefixes.
	function automatic logic [7:0] rmc_char(input logic [POS_W-1:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = "$";
			3'd1: c = "G";
			3'd2: c = "P";
			3'd3: c = "R";
			3'd4: c = "M";
			3'd5: c = "C";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] hdt_char(input logic [POS_W-1:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = "$";
			3'd1: c = "G";
			3'd2: c = "P";
			3'd3: c = "H";
			3'd4: c = "D";
			3'd5: c = "T";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Bit 4 set marks a character that is not an uppercase hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		if (c inside {["0":"9"]}) begin
			v = 5'(c - 8'h30);
		end else if (c inside {["A":"F"]}) begin
			v = 5'(c - 8'h37);
		end else begin
			v = 5'h10;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: sv/nmea_sentence_checksum_check.sv
`default_nettype none
// Checks the XOR checksum of NMEA 0183 sentences fed one character per word on the
// input stream, with tlast on the final character. Each word passes an input register
// and then the update logic into a result register; a character is taken every clock
// unless a final character waits on a result not yet taken; only tlast words give one.
// The sentence is split at '*' into non-empty pieces; checksum_ok is set when there
// are exactly two pieces and the second is two uppercase hex digits equal to the XOR
// of the first piece after its first character. tuser reports the sentence kind from
// the first six characters ($GPRMC or $GPHDT), and the computed XOR is always given.
module nmea_sentence_checksum_check
	import nmea_cks_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  wire logic        s_axis_tlast,   // end_of_sentence
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [0] checksum_ok, [8:1] computed_sum, rest 0
	output logic [1:0]       m_axis_tuser    // [1:0] sentence_kind
);

	// Input register.
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	// Sentence state.
	logic [POS_W-1:0] prefix_pos_q;
	logic             rmc_match_q;
	logic             hdt_match_q;
	logic [7:0]       xor_acc_q;
	logic [1:0]       piece_cnt_q;
	logic             in_piece_q;
	logic [1:0]       piece_pos_q;
	logic [7:0]       rx_sum_q;
	logic             hex_ok_q;

	// Result register.
	logic             out_valid_q;
	logic             out_ok_q;
	kind_t            out_kind_q;
	logic [7:0]       out_sum_q;

	logic             advance;
	logic [POS_W-1:0] prefix_pos_d;
	logic             rmc_match_d;
	logic             hdt_match_d;
	logic [7:0]       xor_acc_d;
	logic [1:0]       piece_cnt_d;
	logic             in_piece_d;
	logic [1:0]       piece_pos_d;
	logic [7:0]       rx_sum_d;
	logic             hex_ok_d;
	logic [1:0]       cur_pos;
	logic [4:0]       hex_v;
	logic             ok_d;
	kind_t            kind_d;

	// A word without tlast never waits on the output side.
	assign advance       = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_comb begin
		prefix_pos_d = prefix_pos_q;
		rmc_match_d  = rmc_match_q;
		hdt_match_d  = hdt_match_q;
		xor_acc_d    = xor_acc_q;
		piece_cnt_d  = piece_cnt_q;
		in_piece_d   = in_piece_q;
		piece_pos_d  = piece_pos_q;
		rx_sum_d     = rx_sum_q;
		hex_ok_d     = hex_ok_q;
		cur_pos      = piece_pos_q;
		hex_v        = hex_value(byte_s1);

		if (prefix_pos_q < POS_W'(PREFIX_LEN)) begin
			if (byte_s1 != rmc_char(prefix_pos_q)) rmc_match_d = 1'b0;
			if (byte_s1 != hdt_char(prefix_pos_q)) hdt_match_d = 1'b0;
			prefix_pos_d = prefix_pos_q + 1'b1;
		end

		if (byte_s1 == STAR_CHAR) begin
			in_piece_d = 1'b0;
		end else begin
			if (!in_piece_q) begin
				in_piece_d = 1'b1;
				if (piece_cnt_q != 2'd3) piece_cnt_d = piece_cnt_q + 1'b1;
				cur_pos = 2'd0;
			end
			if (piece_cnt_d == 2'd1) begin
				if (cur_pos != 2'd0) xor_acc_d = xor_acc_q ^ byte_s1;
			end else if (piece_cnt_d == 2'd2) begin
				if (hex_v[4]) begin
					hex_ok_d = 1'b0;
				end else begin
					rx_sum_d = {rx_sum_q[3:0], hex_v[3:0]};
				end
			end
			piece_pos_d = (cur_pos == 2'd3) ? cur_pos : cur_pos + 1'b1;
		end

		kind_d = KIND_OTHER;
		if (prefix_pos_d == POS_W'(PREFIX_LEN)) begin
			if (rmc_match_d) begin
				kind_d = KIND_RMC;
			end else if (hdt_match_d) begin
				kind_d = KIND_HDT;
			end
		end
		ok_d = (piece_cnt_d == 2'd2) && (piece_pos_d == 2'd2) && hex_ok_d
		       && (rx_sum_d == xor_acc_d);
	end

	// State returns to its idle values after the final character of a sentence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_pos_q <= '0;
			rmc_match_q  <= 1'b1;
			hdt_match_q  <= 1'b1;
			xor_acc_q    <= '0;
			piece_cnt_q  <= '0;
			in_piece_q   <= 1'b0;
			piece_pos_q  <= '0;
			rx_sum_q     <= '0;
			hex_ok_q     <= 1'b1;
		end else if (advance) begin
			if (last_s1) begin
				prefix_pos_q <= '0;
				rmc_match_q  <= 1'b1;
				hdt_match_q  <= 1'b1;
				xor_acc_q    <= '0;
				piece_cnt_q  <= '0;
				in_piece_q   <= 1'b0;
				piece_pos_q  <= '0;
				rx_sum_q     <= '0;
				hex_ok_q     <= 1'b1;
			end else begin
				prefix_pos_q <= prefix_pos_d;
				rmc_match_q  <= rmc_match_d;
				hdt_match_q  <= hdt_match_d;
				xor_acc_q    <= xor_acc_d;
				piece_cnt_q  <= piece_cnt_d;
				in_piece_q   <= in_piece_d;
				piece_pos_q  <= piece_pos_d;
				rx_sum_q     <= rx_sum_d;
				hex_ok_q     <= hex_ok_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_ok_q   <= ok_d;
			out_kind_q <= kind_d;
			out_sum_q  <= xor_acc_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_sum_q, out_ok_q};
	assign m_axis_tuser  = out_kind_q;

`ifndef NO_ASSERTIONS
	// A new result only appears after a final character left the input register.
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && last_s1))
		else $error("result appeared without a final character");

	// Input side only stalls behind a held final character.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && last_s1 && out_valid_q && !m_axis_tready))
		else $error("input stalled without cause");

	// Sentence state is cleared once a sentence is finished.
	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (piece_cnt_q == 2'd0 && xor_acc_q == 8'd0
		&& prefix_pos_q == '0))
		else $error("sentence state not cleared");

	// A passing checksum needs exactly two pieces and valid hex digits, and its sum equals the received digits.
	a_ok_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1 && ok_d) |-> (piece_cnt_d == 2'd2 && hex_ok_d))
		else $error("checksum accepted with malformed checksum field");
`endif

endmodule
`default_nettype wire

FILE: sim/nmea_result_checker.sv
module nmea_result_checker
	import nmea_cks_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  wire logic        s_axis_tlast,   // end_of_sentence
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [15:0] m_axis_tdata,   // [0] checksum_ok, [8:1] computed_sum, rest 0
	input  wire logic [1:0]  m_axis_tuser,   // [1:0] sentence_kind
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       ok;
		kind_t      kind;
		logic [7:0] sum;
	} sentence_result_t;

	localparam logic [47:0] RMC_TEXT = "$GPRMC";
	localparam logic [47:0] HDT_TEXT = "$GPHDT";

	sentence_result_t sentence_results[$];

	// Running view of the sentence that is being taken in.
	logic [2:0] prefix_idx;
	logic       rmc_hit;
	logic       hdt_hit;
	logic [7:0] run_xor;
	logic [1:0] pieces;
	logic       in_piece;
	logic [1:0] piece_pos;
	logic [7:0] sum_rx;
	logic       digits_ok;
	int         errors = 0;

	assign fail_count = errors;

	function automatic logic [7:0] prefix_byte(input logic [47:0] text, input int idx);
		return text[47 - 8 * idx -: 8];
	endfunction

	// Bit 4 flags a character that is not an uppercase hex digit.
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) begin
			return {1'b0, c[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			return {1'b0, 4'(c - 8'h37)};
		end
		return 5'h10;
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	task automatic clear_sentence();
		prefix_idx = '0;
		rmc_hit    = 1'b1;
		hdt_hit    = 1'b1;
		run_xor    = '0;
		pieces     = '0;
		in_piece   = 1'b0;
		piece_pos  = '0;
		sum_rx     = '0;
		digits_ok  = 1'b1;
	endtask

	task automatic absorb_char(input logic [7:0] c, input logic last);
		logic [4:0]       v;
		sentence_result_t res;
		if (prefix_idx < PREFIX_LEN) begin
			if (c != prefix_byte(RMC_TEXT, prefix_idx))
				rmc_hit = 1'b0;
			if (c != prefix_byte(HDT_TEXT, prefix_idx))
				hdt_hit = 1'b0;
			prefix_idx++;
		end
		if (c == STAR_CHAR) begin
			in_piece = 1'b0;
		end else begin
			if (!in_piece) begin
				in_piece = 1'b1;
				if (pieces < 2'd3)
					pieces++;
				piece_pos = '0;
			end
			if (pieces == 2'd1) begin
				// The leading character of the first piece stays out of the sum.
				if (piece_pos >= 2'd1)
					run_xor ^= c;
			end else if (pieces == 2'd2) begin
				v = nibble_of(c);
				if (v[4])
					digits_ok = 1'b0;
				else
					sum_rx = {sum_rx[3:0], v[3:0]};
			end
			if (piece_pos < 2'd3)
				piece_pos++;
		end
		if (last) begin
			res.kind = KIND_OTHER;
			if (prefix_idx >= PREFIX_LEN) begin
				if (rmc_hit)
					res.kind = KIND_RMC;
				else if (hdt_hit)
					res.kind = KIND_HDT;
			end
			res.ok  = (pieces == 2'd2) && (piece_pos == 2'd2) && digits_ok
				&& (sum_rx == run_xor);
			res.sum = run_xor;
			sentence_results = {sentence_results, res};
			clear_sentence();
		end
	endtask

	task automatic check_result();
		sentence_result_t want;
		if (sentence_results.size() == 0) begin
			report_mismatch($sformatf("result word %h/%h with no sentence pending",
				m_axis_tdata, m_axis_tuser));
		end else begin
			want = sentence_results.pop_front();
			if (m_axis_tdata[0] !== want.ok)
				report_mismatch($sformatf("checksum_ok got %b, want %b",
					m_axis_tdata[0], want.ok));
			if (m_axis_tdata[8:1] !== want.sum)
				report_mismatch($sformatf("computed_sum got %h, want %h",
					m_axis_tdata[8:1], want.sum));
			if (m_axis_tdata[15:9] !== 7'd0)
				report_mismatch($sformatf("tdata padding got %h, want 0",
					m_axis_tdata[15:9]));
			if (m_axis_tuser !== want.kind)
				report_mismatch($sformatf("sentence_kind got %0d, want %0d",
					m_axis_tuser, want.kind));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_sentence();
			sentence_results.delete();
			pending <= 0;
		end else begin
			// A result leaving in the same cycle belongs to an older sentence.
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			if (s_axis_tvalid && s_axis_tready)
				absorb_char(s_axis_tdata, s_axis_tlast);
			pending <= sentence_results.size();
		end
	end

endmodule

FILE: sim/tb_nmea_sentence_checksum_check.sv
module tb_nmea_sentence_checksum_check
	import nmea_cks_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 317;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] text_byte
	logic        s_axis_tlast;   // end_of_sentence
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // [0] checksum_ok, [8:1] computed_sum, rest 0
	logic [1:0]  m_axis_tuser;   // [1:0] sentence_kind
	int          fail_count;
	int          pending;

	int          send_idle;
	int          recv_idle;
	bit          hold_req;
	int          items_sent;
	int          stalled;
	logic [7:0]  line_bytes[$];

	nmea_sentence_checksum_check dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	nmea_result_checker result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
	endfunction

	function automatic logic [7:0] lower_char(input logic [7:0] c);
		return (c >= 8'h41) ? c + 8'h20 : c;
	endfunction

	function automatic logic [7:0] body_char();
		logic [7:0] c;
		c = 8'($urandom_range(8'h7E, 8'h20));
		if (c == STAR_CHAR)
			c = 8'h2C;
		return c;
	endfunction

	// XOR of everything after the first character, as a sender would compute it.
	function automatic logic [7:0] line_sum();
		logic [7:0] x;
		x = '0;
		for (int i = 1; i < line_bytes.size(); i++)
			x ^= line_bytes[i];
		return x;
	endfunction

	task automatic append_byte(input logic [7:0] b);
		line_bytes = {line_bytes, b};
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			append_byte(s[i]);
	endtask

	task automatic add_body(input int n);
		repeat (n) append_byte(body_char());
	endtask

	task automatic add_sum_tail(input logic [7:0] flip);
		logic [7:0] sum;
		sum = line_sum() ^ flip;
		append_byte(STAR_CHAR);
		append_byte(hex_char(sum[7:4]));
		append_byte(hex_char(sum[3:0]));
	endtask

	task automatic send_word(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic send_line();
		for (int i = 0; i < line_bytes.size(); i++)
			send_word(line_bytes[i], i == line_bytes.size() - 1);
		items_sent += line_bytes.size();
		line_bytes.delete();
	endtask

	task automatic make_sentence();
		int         r;
		logic [7:0] sum;
		r = $urandom_range(99);
		if (r < 65) begin
			// Well-formed framing with a random prefix and body.
			case ($urandom_range(3))
				0: add_text("$GPRMC");
				1: add_text("$GPHDT");
				2: begin
					add_text("$GP");
					repeat (3) append_byte(8'($urandom_range(8'h5A, 8'h41)));
				end
				default: begin
					add_text($urandom_range(1) ? "$GPRMC" : "$GPHDT");
					line_bytes[$urandom_range(5)] = body_char();
				end
			endcase
			add_body($urandom_range(12));
			add_sum_tail(($urandom_range(9) == 0) ? 8'(1 << $urandom_range(7)) : 8'h00);
		end else if (r < 80) begin
			// Broken or unusual checksum tails.
			append_byte(8'h24);
			add_body($urandom_range(8));
			sum = line_sum();
			case ($urandom_range(5))
				0: begin
					append_byte(STAR_CHAR);
					append_byte(lower_char(hex_char(sum[7:4])));
					append_byte(lower_char(hex_char(sum[3:0])));
				end
				1: begin
					append_byte(STAR_CHAR);
					append_byte(hex_char(sum[3:0]));
				end
				2: begin
					add_sum_tail(8'h00);
					append_byte(hex_char(4'($urandom_range(15))));
				end
				3: begin
					append_byte(STAR_CHAR);
					add_sum_tail(8'h00);
				end
				4: begin
					add_sum_tail(8'h00);
					append_byte(STAR_CHAR);
					line_bytes.push_front(STAR_CHAR);
				end
				default: begin
					add_sum_tail(8'h00);
					append_byte(STAR_CHAR);
					append_byte(body_char());
				end
			endcase
		end else begin
			// Raw bytes over the whole range, with plenty of stars.
			repeat ($urandom_range(12, 1)) begin
				if ($urandom_range(3) == 0)
					append_byte(STAR_CHAR);
				else
					append_byte(8'($urandom_range(255)));
			end
		end
	endtask

	// The receiver runs on its own; one long hold-off lets the block back up.
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	initial begin
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stalled = 0;
			else
				stalled++;
		end
		$display("** nmea_sentence_checksum_check: FAILED **");
		$finish;
	end

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		arst_n        = 1'b0;
		send_idle     = 19;
		recv_idle     = 73;
		hold_req      = 1'b0;
		items_sent    = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A lone star, then the byte extremes, each as a one-word sentence.
		append_byte(STAR_CHAR);
		send_line();
		append_byte(8'hFF);
		send_line();
		append_byte(8'h00);
		send_line();
		// A first piece of one character sums to zero.
		add_text("$*00");
		send_line();
		add_text("$GPRMC");
		add_sum_tail(8'h00);
		send_line();
		add_text("$GPHDT");
		add_sum_tail(8'h00);
		send_line();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 19;
					recv_idle = 73;
				end
				1: begin
					send_idle = 73;
					recv_idle = 19;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
					hold_req  = 1'b1;
				end
			endcase
			while (items_sent < (phase + 1) * PHASE_ITEMS) begin
				make_sentence();
				send_line();
			end
		end
		s_axis_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("** nmea_sentence_checksum_check: PASSED **");
		else
			$display("** nmea_sentence_checksum_check: FAILED **");
		$finish;
	end

endmodule
